### design/assert_macros.svh
// Assertion macros shared by the ball physics RTL.
// Users must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/bps_pkg.sv
// Ball physics step package: ball record, divider and square-root request types,
// saturation helper. No dependencies.
package bps_pkg;

	localparam int BALL_COUNT_DEF = 4;

	localparam int DIV_N  = 49;	// dividend and quotient width
	localparam int DIV_D  = 33;	// divisor width
	localparam int SQ_IN  = 55;	// radicand width
	localparam int SQ_OUT = 28;	// root width

	localparam logic [20:0] GRAVITY_RST = 21'd26214;
	localparam logic [11:0] WIDTH_RST   = 12'd1920;
	localparam logic [11:0] HEIGHT_RST  = 12'd1080;
	localparam logic [20:0] REST_RST    = 21'd22348;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic [25:0]        r;
		logic [31:0]        m;
		logic [16:0]        e;
		logic [31:0]        f;
	} ball_t;

	typedef struct packed {
		logic             start;
		logic [DIV_N-1:0] dividend;
		logic [DIV_D-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic [DIV_N-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic             start;
		logic [SQ_IN-1:0] radicand;
	} sqrt_req_t;

	typedef struct packed {
		logic              busy;
		logic [SQ_OUT-1:0] root;
	} sqrt_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		if (v < -64'sh8000_0000)
			return -32'sh8000_0000;
		return v[31:0];
	endfunction

endpackage

### design/bps_ram.sv
// Generic synchronous RAM: one write port, one read port, registered read data.
// No dependencies.
module bps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

### design/bps_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on bps_pkg. A zero divisor yields an all-ones quotient.
module bps_div import bps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic             busy_q;
	logic [5:0]       cnt_q;
	logic [DIV_D-1:0] rem_q;
	logic [DIV_D-1:0] dsr_q;
	logic [DIV_N-1:0] quo_q;
	logic [DIV_D:0]   shifted;
	logic             fits;

	assign shifted = {rem_q, quo_q[DIV_N-1]};
	assign fits    = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'(DIV_N - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_D'(shifted - {1'b0, dsr_q}) : shifted[DIV_D-1:0];
			quo_q <= {quo_q[DIV_N-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.quotient = quo_q;

endmodule

### design/bps_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on bps_pkg.
module bps_sqrt import bps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  sqrt_req_t req,
	output sqrt_rsp_t rsp
);

	logic                busy_q;
	logic [4:0]          cnt_q;
	logic [2*SQ_OUT-1:0] rad_q;
	logic [SQ_OUT+1:0]   rem_q;
	logic [SQ_OUT-1:0]   root_q;
	logic [SQ_OUT+3:0]   shifted;
	logic [SQ_OUT+3:0]   trial;
	logic                fits;

	assign shifted = {rem_q, rad_q[2*SQ_OUT-1 -: 2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign fits    = shifted >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'(SQ_OUT - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= (2*SQ_OUT)'(req.radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? (SQ_OUT+2)'(shifted - trial) : shifted[SQ_OUT+1:0];
			root_q <= {root_q[SQ_OUT-2:0], fits};
			rad_q  <= {rad_q[2*SQ_OUT-3:0], 2'b00};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.root = root_q;

endmodule

### design/ball_physics_step_top.sv
// Ball physics step, top level. Depends on bps_pkg, bps_ram, bps_div, bps_sqrt, assert_macros.svh.
// Load: taken when idle; no result. Tick: each ball moved in turn (a floor hit adds a divide on
// the shared divider for friction), then each pair resolved (a root if close, four divides if
// touching), then one result per ball, held while the output stalls. One item at a time.
// Reset: control and config registers to defaults; the ball RAM is undefined until loaded.
module ball_physics_step_top import bps_pkg::*; #(
	parameter int BALL_COUNT = BALL_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [20:0]        cfg_data,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [3:0]         ball_index,
	input  logic signed [31:0] load_x,
	input  logic signed [31:0] load_y,
	input  logic signed [31:0] load_vx,
	input  logic signed [31:0] load_vy,
	input  logic [25:0]        load_radius,
	input  logic [31:0]        load_mass,
	input  logic [16:0]        load_elasticity,
	input  logic [31:0]        load_friction,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         out_index,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_vx,
	output logic signed [31:0] out_vy,
	output logic               last
);

`include "assert_macros.svh"

	localparam int AW = $clog2(BALL_COUNT);
	localparam logic [AW-1:0] IDX_LAST = AW'(BALL_COUNT - 1);
	localparam logic [AW-1:0] IDX_PEN  = AW'(BALL_COUNT - 2);

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [1:0] REG_GRAVITY = 2'd0;
	localparam logic [1:0] REG_WIDTH   = 2'd1;
	localparam logic [1:0] REG_HEIGHT  = 2'd2;
	localparam logic [1:0] REG_REST    = 2'd3;

	// Sequencer states. M_*: per-ball move, P_*: pair resolve, E_*: result emit.
	localparam logic [5:0] S_IDLE  = 6'd0;
	localparam logic [5:0] M_RD    = 6'd1;
	localparam logic [5:0] M_LD    = 6'd2;
	localparam logic [5:0] M_G     = 6'd3;
	localparam logic [5:0] M_Y     = 6'd4;
	localparam logic [5:0] M_FC    = 6'd5;
	localparam logic [5:0] M_FL    = 6'd6;
	localparam logic [5:0] M_FL2   = 6'd7;
	localparam logic [5:0] M_RT    = 6'd8;
	localparam logic [5:0] M_FW    = 6'd9;
	localparam logic [5:0] M_FR    = 6'd10;
	localparam logic [5:0] M_CE    = 6'd11;
	localparam logic [5:0] M_CE2   = 6'd12;
	localparam logic [5:0] M_X     = 6'd13;
	localparam logic [5:0] M_RW    = 6'd14;
	localparam logic [5:0] M_LW    = 6'd15;
	localparam logic [5:0] M_WR    = 6'd16;
	localparam logic [5:0] P_RDA   = 6'd17;
	localparam logic [5:0] P_RDB   = 6'd18;
	localparam logic [5:0] P_LDB   = 6'd19;
	localparam logic [5:0] P_D     = 6'd20;
	localparam logic [5:0] P_CHK   = 6'd21;
	localparam logic [5:0] P_SQ    = 6'd22;
	localparam logic [5:0] P_SQS   = 6'd23;
	localparam logic [5:0] P_SQW   = 6'd24;
	localparam logic [5:0] P_DC    = 6'd25;
	localparam logic [5:0] P_NXS   = 6'd26;
	localparam logic [5:0] P_NXW   = 6'd27;
	localparam logic [5:0] P_NYS   = 6'd28;
	localparam logic [5:0] P_NYW   = 6'd29;
	localparam logic [5:0] P_S1S   = 6'd30;
	localparam logic [5:0] P_S1W   = 6'd31;
	localparam logic [5:0] P_S2S   = 6'd32;
	localparam logic [5:0] P_S2W   = 6'd33;
	localparam logic [5:0] P_RV1   = 6'd34;
	localparam logic [5:0] P_RV2   = 6'd35;
	localparam logic [5:0] P_OV    = 6'd36;
	localparam logic [5:0] P_IM1   = 6'd37;
	localparam logic [5:0] P_IM2   = 6'd38;
	localparam logic [5:0] P_IM3   = 6'd39;
	localparam logic [5:0] P_IM4   = 6'd40;
	localparam logic [5:0] P_WA    = 6'd41;
	localparam logic [5:0] P_WB    = 6'd42;
	localparam logic [5:0] P_NEXT  = 6'd43;
	localparam logic [5:0] E_RD    = 6'd44;
	localparam logic [5:0] E_LD    = 6'd45;
	localparam logic [5:0] E_WT    = 6'd46;

	// control
	logic [5:0]    state_q;
	logic [AW-1:0] ia_q;
	logic [AW-1:0] ib_q;
	logic          out_valid_q;
	logic [20:0]   grav_q;
	logic [11:0]   scr_w_q;
	logic [11:0]   scr_h_q;
	logic [20:0]   rest_q;

	// working copies of the two balls in flight
	ball_t ra_q;
	ball_t rb_q;
	ball_t rd_ball;

	// move datapath
	logic signed [29:0] fl_q;
	logic signed [29:0] rw_q;
	logic signed [49:0] prod_q;
	logic [30:0]        fq_q;

	// pair datapath
	logic signed [32:0] dx_q, dy_q, dvx_q, dvy_q;
	logic [26:0]        dmin_q, adx_q, ady_q, ov_q;
	logic [53:0]        dxx_q, dyy_q;
	logic [27:0]        dist_q;
	logic [32:0]        tot_q;
	logic signed [17:0] nx_q, ny_q;
	logic [16:0]        s1_q, s2_q;
	logic signed [50:0] pvx_q, pvy_q;
	logic signed [45:0] tx_q, ty_q;
	logic signed [35:0] rvn_q;
	logic signed [63:0] cxa_q, cya_q, cxb_q, cyb_q;
	logic [16:0]        emin_q;
	logic [34:0]        nrv_q;
	logic [35:0]        imp_q, w1_q, w2_q;
	logic signed [39:0] uax_q, uay_q, ubx_q, uby_q;

	// result register
	logic [3:0]         out_index_q;
	logic signed [31:0] out_x_q, out_y_q, out_vx_q, out_vy_q;
	logic               last_q;

	// RAM ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	ball_t         ram_wdata;

	div_req_t  div_req;
	div_rsp_t  div_rsp;
	sqrt_req_t sq_req;
	sqrt_rsp_t sq_rsp;

	// decisions
	logic               in_xfer, load_xfer, tick_xfer, out_xfer;
	logic               floor_hit, ceil_hit, rest_hit, pair_skip, dc_skip;
	logic [32:0]        adx, ady, vy_abs, tot;
	logic signed [32:0] vx_dn, vx_up;
	logic [17:0]        nq;

	assign in_xfer   = in_valid && !in_stall;
	assign load_xfer = in_xfer && (kind == KIND_LOAD) && ({1'b0, ball_index} < 5'(BALL_COUNT));
	assign tick_xfer = in_xfer && (kind == KIND_TICK);
	assign out_xfer  = out_valid_q && !out_stall;

	assign floor_hit = 64'(ra_q.y) >= 64'(fl_q);
	assign ceil_hit  = 64'(ra_q.y) <= 64'($signed({1'b0, ra_q.r}));
	assign vy_abs    = ra_q.vy[31] ? 33'(-(33'(ra_q.vy))) : 33'(ra_q.vy);
	assign rest_hit  = vy_abs < {12'b0, rest_q};
	assign vx_dn     = 33'(ra_q.vx) - $signed({2'b00, fq_q});
	assign vx_up     = 33'(ra_q.vx) + $signed({2'b00, fq_q});

	assign adx       = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
	assign ady       = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
	assign pair_skip = (dx_q == '0 && dy_q == '0) || adx >= 33'(dmin_q) || ady >= 33'(dmin_q);
	assign tot       = 33'(ra_q.m) + 33'(rb_q.m);
	assign dc_skip   = (28'(dmin_q) <= dist_q) || (tot == '0);
	assign nq        = div_rsp.quotient[17:0];

	// left wall test on the current x
	function automatic logic ceil_hit_x();
		return 64'(ra_q.x) <= 64'($signed({1'b0, ra_q.r}));
	endfunction

	// ---------------------------------------------------------------------
	// Ball table: one entry per ball, read-modify-write. Every write state is
	// sequenced before any later read of the same entry, so no forwarding.
	// ---------------------------------------------------------------------
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ia_q;
		ram_wdata = ra_q;
		ram_raddr = ia_q;
		unique case (state_q)
			S_IDLE: begin
				ram_we    = load_xfer;
				ram_waddr = ball_index[AW-1:0];
				ram_wdata.x  = load_x;
				ram_wdata.y  = load_y;
				ram_wdata.vx = load_vx;
				ram_wdata.vy = load_vy;
				ram_wdata.r  = load_radius;
				ram_wdata.m  = load_mass;
				ram_wdata.e  = load_elasticity;
				ram_wdata.f  = load_friction;
			end
			M_WR, P_WA: begin
				ram_we = 1'b1;
			end
			P_WB: begin
				ram_we    = 1'b1;
				ram_waddr = ib_q;
				ram_wdata = rb_q;
			end
			P_RDB: begin
				ram_raddr = ib_q;
			end
			default: begin
			end
		endcase
	end

	bps_ram #(
		.WIDTH ($bits(ball_t)),
		.DEPTH (BALL_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_ball)
	);

	// Shared divider: floor friction, then per pair nx, ny, s1, s2.
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = {1'b0, ra_q.f, 16'b0};
		div_req.divisor  = {1'b0, ra_q.m};
		unique case (state_q)
			M_RT: begin
				div_req.start = 1'b1;
			end
			P_NXS: begin
				div_req.start    = 1'b1;
				div_req.dividend = {6'b0, adx_q, 16'b0};
				div_req.divisor  = {5'b0, dist_q};
			end
			P_NYS: begin
				div_req.start    = 1'b1;
				div_req.dividend = {6'b0, ady_q, 16'b0};
				div_req.divisor  = {5'b0, dist_q};
			end
			P_S1S: begin
				div_req.start    = 1'b1;
				div_req.dividend = {1'b0, ra_q.m, 16'b0};
				div_req.divisor  = tot_q;
			end
			P_S2S: begin
				div_req.start    = 1'b1;
				div_req.dividend = {1'b0, rb_q.m, 16'b0};
				div_req.divisor  = tot_q;
			end
			default: begin
			end
		endcase
	end

	bps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign sq_req.start    = (state_q == P_SQS);
	assign sq_req.radicand = 55'(dxx_q) + 55'(dyy_q);

	bps_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.rsp    (sq_rsp)
	);

	// ---------------------------------------------------------------------
	// Sequencer and config registers.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ia_q        <= '0;
			ib_q        <= '0;
			out_valid_q <= 1'b0;
			grav_q      <= GRAVITY_RST;
			scr_w_q     <= WIDTH_RST;
			scr_h_q     <= HEIGHT_RST;
			rest_q      <= REST_RST;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GRAVITY: grav_q  <= cfg_data;
					REG_WIDTH:   scr_w_q <= cfg_data[11:0];
					REG_HEIGHT:  scr_h_q <= cfg_data[11:0];
					REG_REST:    rest_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (tick_xfer) begin
						ia_q    <= '0;
						state_q <= M_RD;
					end
				end
				M_RD:  state_q <= M_LD;
				M_LD:  state_q <= M_G;
				M_G:   state_q <= M_Y;
				M_Y:   state_q <= M_FC;
				M_FC:  state_q <= floor_hit ? M_FL : M_CE;
				M_FL:  state_q <= M_FL2;
				M_FL2: state_q <= M_RT;
				M_RT:  state_q <= M_FW;
				M_FW: begin
					if (!div_rsp.busy)
						state_q <= M_FR;
				end
				M_FR:  state_q <= M_CE;
				M_CE:  state_q <= ceil_hit ? M_CE2 : M_X;
				M_CE2: state_q <= M_X;
				M_X:   state_q <= M_RW;
				M_RW:  state_q <= M_LW;
				M_LW:  state_q <= M_WR;
				M_WR: begin
					if (ia_q == IDX_LAST) begin
						ia_q    <= '0;
						ib_q    <= AW'(1);
						state_q <= P_RDA;
					end else begin
						ia_q    <= ia_q + AW'(1);
						state_q <= M_RD;
					end
				end
				P_RDA: state_q <= P_RDB;
				P_RDB: state_q <= P_LDB;
				P_LDB: state_q <= P_D;
				P_D:   state_q <= P_CHK;
				P_CHK: state_q <= pair_skip ? P_NEXT : P_SQ;
				P_SQ:  state_q <= P_SQS;
				P_SQS: state_q <= P_SQW;
				P_SQW: begin
					if (!sq_rsp.busy)
						state_q <= P_DC;
				end
				P_DC:  state_q <= dc_skip ? P_NEXT : P_NXS;
				P_NXS: state_q <= P_NXW;
				P_NXW: begin
					if (!div_rsp.busy)
						state_q <= P_NYS;
				end
				P_NYS: state_q <= P_NYW;
				P_NYW: begin
					if (!div_rsp.busy)
						state_q <= P_S1S;
				end
				P_S1S: state_q <= P_S1W;
				P_S1W: begin
					if (!div_rsp.busy)
						state_q <= P_S2S;
				end
				P_S2S: state_q <= P_S2W;
				P_S2W: begin
					if (!div_rsp.busy)
						state_q <= P_RV1;
				end
				P_RV1: state_q <= P_RV2;
				P_RV2: state_q <= P_OV;
				// separating pairs get the overlap fix only
				P_OV:  state_q <= (rvn_q > 36'sd0) ? P_WA : P_IM1;
				P_IM1: state_q <= P_IM2;
				P_IM2: state_q <= P_IM3;
				P_IM3: state_q <= P_IM4;
				P_IM4: state_q <= P_WA;
				P_WA:  state_q <= P_WB;
				P_WB:  state_q <= P_NEXT;
				P_NEXT: begin
					if (ib_q == IDX_LAST) begin
						if (ia_q == IDX_PEN) begin
							ia_q    <= '0;
							state_q <= E_RD;
						end else begin
							ia_q    <= ia_q + AW'(1);
							ib_q    <= ia_q + AW'(2);
							state_q <= P_RDA;
						end
					end else begin
						ib_q    <= ib_q + AW'(1);
						state_q <= P_RDA;
					end
				end
				E_RD:  state_q <= E_LD;
				E_LD: begin
					out_valid_q <= 1'b1;
					state_q     <= E_WT;
				end
				E_WT: begin
					if (out_xfer) begin
						out_valid_q <= 1'b0;
						if (ia_q == IDX_LAST) begin
							state_q <= S_IDLE;
						end else begin
							ia_q    <= ia_q + AW'(1);
							state_q <= E_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Datapath: one arithmetic step per state.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			M_LD: begin
				ra_q <= rd_ball;
				fl_q <= $signed({2'b00, scr_h_q, 16'b0}) - $signed({4'b0, rd_ball.r});
				rw_q <= $signed({2'b00, scr_w_q, 16'b0}) - $signed({4'b0, rd_ball.r});
			end
			M_G:   ra_q.vy <= sat32(64'(ra_q.vy) + 64'($signed({1'b0, grav_q})));
			M_Y:   ra_q.y  <= sat32(64'(ra_q.y) + 64'(ra_q.vy));
			M_FL: begin
				ra_q.y <= 32'(fl_q);
				prod_q <= 50'(ra_q.vy) * 50'($signed({1'b0, ra_q.e}));
			end
			M_FL2: ra_q.vy <= sat32(64'((-prod_q) >>> 16));
			M_RT: begin
				if (rest_hit)
					ra_q.vy <= '0;
			end
			M_FW: begin
				// friction per contact, clipped to 31 bits (also covers zero mass)
				fq_q <= (|div_rsp.quotient[DIV_N-1:31]) ? 31'h7FFF_FFFF
					: div_rsp.quotient[30:0];
			end
			M_FR: begin
				if (ra_q.vx > 32'sd0)
					ra_q.vx <= (vx_dn < 33'sd0) ? 32'sd0 : 32'(vx_dn);
				else if (ra_q.vx < 32'sd0)
					ra_q.vx <= (vx_up > 33'sd0) ? 32'sd0 : 32'(vx_up);
			end
			M_CE: begin
				if (ceil_hit) begin
					ra_q.y <= 32'(ra_q.r);
					prod_q <= 50'(ra_q.vy) * 50'($signed({1'b0, ra_q.e}));
				end
			end
			M_CE2: ra_q.vy <= sat32(64'((-prod_q) >>> 16));
			M_X:   ra_q.x  <= sat32(64'(ra_q.x) + 64'(ra_q.vx));
			M_RW: begin
				if (64'(ra_q.x) >= 64'(rw_q)) begin
					ra_q.x  <= sat32((64'(rw_q) <<< 1) - 64'(ra_q.x));
					ra_q.vx <= sat32(-64'(ra_q.vx));
				end
			end
			M_LW: begin
				if (ceil_hit_x()) begin
					ra_q.x  <= sat32((64'($signed({1'b0, ra_q.r})) <<< 1) - 64'(ra_q.x));
					ra_q.vx <= sat32(-64'(ra_q.vx));
				end
			end
			P_RDB: ra_q <= rd_ball;
			P_LDB: rb_q <= rd_ball;
			P_D: begin
				dx_q   <= 33'(rb_q.x) - 33'(ra_q.x);
				dy_q   <= 33'(rb_q.y) - 33'(ra_q.y);
				dvx_q  <= 33'(rb_q.vx) - 33'(ra_q.vx);
				dvy_q  <= 33'(rb_q.vy) - 33'(ra_q.vy);
				dmin_q <= 27'(ra_q.r) + 27'(rb_q.r);
			end
			P_CHK: begin
				adx_q <= adx[26:0];
				ady_q <= ady[26:0];
			end
			P_SQ: begin
				dxx_q <= 54'(adx_q) * 54'(adx_q);
				dyy_q <= 54'(ady_q) * 54'(ady_q);
			end
			P_SQW: dist_q <= sq_rsp.root;
			P_DC: begin
				tot_q <= tot;
				ov_q  <= 27'(28'(dmin_q) - dist_q);
			end
			P_NXW: nx_q <= dx_q[32] ? -$signed(nq) : $signed(nq);
			P_NYW: ny_q <= dy_q[32] ? -$signed(nq) : $signed(nq);
			P_S1W: s1_q <= div_rsp.quotient[16:0];
			P_S2W: s2_q <= div_rsp.quotient[16:0];
			P_RV1: begin
				pvx_q <= 51'(dvx_q) * 51'(nx_q);
				pvy_q <= 51'(dvy_q) * 51'(ny_q);
				tx_q  <= 46'(nx_q) * 46'($signed({1'b0, ov_q}));
				ty_q  <= 46'(ny_q) * 46'($signed({1'b0, ov_q}));
			end
			P_RV2: begin
				rvn_q <= 36'((52'(pvx_q) + 52'(pvy_q)) >>> 16);
				cxa_q <= 64'(tx_q) * 64'($signed({1'b0, s2_q}));
				cya_q <= 64'(ty_q) * 64'($signed({1'b0, s2_q}));
				cxb_q <= 64'(tx_q) * 64'($signed({1'b0, s1_q}));
				cyb_q <= 64'(ty_q) * 64'($signed({1'b0, s1_q}));
			end
			P_OV: begin
				// mass-weighted overlap correction
				ra_q.x <= sat32(64'(ra_q.x) - (cxa_q >>> 32));
				ra_q.y <= sat32(64'(ra_q.y) - (cya_q >>> 32));
				rb_q.x <= sat32(64'(rb_q.x) + (cxb_q >>> 32));
				rb_q.y <= sat32(64'(rb_q.y) + (cyb_q >>> 32));
				emin_q <= (ra_q.e < rb_q.e) ? ra_q.e : rb_q.e;
				nrv_q  <= 35'(-rvn_q);
			end
			P_IM1: imp_q <= 36'((53'(nrv_q) * 53'(18'(emin_q) + 18'd65536)) >> 16);
			P_IM2: begin
				w1_q <= 36'((53'(imp_q) * 53'(s2_q)) >> 16);
				w2_q <= 36'((53'(imp_q) * 53'(s1_q)) >> 16);
			end
			P_IM3: begin
				uax_q <= 40'((56'($signed({1'b0, w1_q})) * 56'(nx_q)) >>> 16);
				uay_q <= 40'((56'($signed({1'b0, w1_q})) * 56'(ny_q)) >>> 16);
				ubx_q <= 40'((56'($signed({1'b0, w2_q})) * 56'(nx_q)) >>> 16);
				uby_q <= 40'((56'($signed({1'b0, w2_q})) * 56'(ny_q)) >>> 16);
			end
			P_IM4: begin
				ra_q.vx <= sat32(64'(ra_q.vx) - 64'(uax_q));
				ra_q.vy <= sat32(64'(ra_q.vy) - 64'(uay_q));
				rb_q.vx <= sat32(64'(rb_q.vx) + 64'(ubx_q));
				rb_q.vy <= sat32(64'(rb_q.vy) + 64'(uby_q));
			end
			E_LD: begin
				out_index_q <= 4'(ia_q);
				out_x_q     <= rd_ball.x;
				out_y_q     <= rd_ball.y;
				out_vx_q    <= rd_ball.vx;
				out_vy_q    <= rd_ball.vy;
				last_q      <= (ia_q == IDX_LAST);
			end
			default: begin
			end
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_vx    = out_vx_q;
	assign out_vy    = out_vy_q;
	assign last      = last_q;

	`ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy, "divider started while busy")
	`ASSERT_IMP(a_sqrt_start_idle, sq_req.start, !sq_rsp.busy, "square root started while busy")
	`ASSERT_NXT(a_tick_starts, tick_xfer, in_stall, "tick transfer did not start work")
	`ASSERT_NXT(a_last_ends, out_xfer && last_q, !in_stall, "final result did not end the tick")

endmodule

### verif/ball_physics_step_checker.sv
// Checker for ball_physics_step_top: watches the load/tick and result channels,
// predicts per-ball state after each tick and compares. Depends on bps_pkg.
module ball_physics_step_checker import bps_pkg::*; #(
	parameter int BALL_COUNT = BALL_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [20:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               kind,
	input  logic [3:0]         ball_index,
	input  logic signed [31:0] load_x,
	input  logic signed [31:0] load_y,
	input  logic signed [31:0] load_vx,
	input  logic signed [31:0] load_vy,
	input  logic [25:0]        load_radius,
	input  logic [31:0]        load_mass,
	input  logic [16:0]        load_elasticity,
	input  logic [31:0]        load_friction,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [3:0]         out_index,
	input  logic signed [31:0] out_x,
	input  logic signed [31:0] out_y,
	input  logic signed [31:0] out_vx,
	input  logic signed [31:0] out_vy,
	input  logic               last,
	output int                 errors,
	output int                 pending
);

	localparam logic KIND_LOAD = 1'b0;
	localparam logic [1:0] REG_GRAVITY = 2'd0, REG_WIDTH = 2'd1, REG_HEIGHT = 2'd2,
		REG_REST = 2'd3;

	typedef struct packed {
		logic [3:0]         idx;
		logic signed [31:0] x, y, vx, vy;
		logic               lst;
	} ball_report_t;

	logic [20:0] grav_q;
	logic [11:0] width_q, height_q;
	logic [20:0] rest_q;
	ball_t       balls[BALL_COUNT];
	ball_report_t expected_reports[$];

	assign pending = expected_reports.size();

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint fdiv(longint p, longint d);
		longint q;
		q = p / d;
		if (p % d != 0 && p < 0) q--;
		return q;
	endfunction

	function automatic longint int_root(longint unsigned s);
		longint unsigned res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > s) bit_v >>= 2;
		while (bit_v != 0) begin
			if (s >= res + bit_v) begin
				s -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else
				res >>= 1;
			bit_v >>= 2;
		end
		return longint'(res);
	endfunction

	task automatic advance_ball(int b);
		longint r, e, x, y, vx, vy, fl, rw, av;
		longint unsigned fr;
		r = balls[b].r; e = balls[b].e;
		x = balls[b].x; y = balls[b].y; vx = balls[b].vx; vy = balls[b].vy;
		fl = longint'(height_q) * 65536 - r;
		rw = longint'(width_q) * 65536 - r;
		vy = clip32(vy + longint'(grav_q));
		y = clip32(y + vy);
		if (y >= fl) begin
			y = fl;
			vy = clip32(fdiv(-(vy * e), 65536));
			av = vy < 0 ? -vy : vy;
			if (av < longint'(rest_q)) vy = 0;
			fr = 64'h7FFF_FFFF;
			if (balls[b].m != 0) begin
				fr = ({32'd0, balls[b].f} << 16) / {32'd0, balls[b].m};
				if (fr > 64'h7FFF_FFFF) fr = 64'h7FFF_FFFF;
			end
			if (vx > 0) begin
				vx -= longint'(fr);
				if (vx < 0) vx = 0;
			end else if (vx < 0) begin
				vx += longint'(fr);
				if (vx > 0) vx = 0;
			end
		end
		if (y <= r) begin
			y = r;
			vy = clip32(fdiv(-(vy * e), 65536));
		end
		x = clip32(x + vx);
		if (x >= rw) begin
			x = clip32(2 * rw - x);
			vx = clip32(-vx);
		end
		if (x <= r) begin
			x = clip32(2 * r - x);
			vx = clip32(-vx);
		end
		balls[b].x = clip32(x); balls[b].y = clip32(y);
		balls[b].vx = clip32(vx); balls[b].vy = clip32(vy);
	endtask

	task automatic collide(int a, int b);
		longint dx, dy, dmin, adx, ady, dist_v, nx, ny, rvn, ov, s1, s2, imp, w1, w2, e;
		longint unsigned tot;
		dx = longint'(balls[b].x) - longint'(balls[a].x);
		dy = longint'(balls[b].y) - longint'(balls[a].y);
		dmin = longint'(balls[a].r) + longint'(balls[b].r);
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		if (dx == 0 && dy == 0) return;
		if (adx >= dmin || ady >= dmin) return;
		dist_v = int_root(longint'(dx * dx) + longint'(dy * dy));
		if (dist_v >= dmin || dist_v == 0) return;
		tot = longint'(balls[a].m) + longint'(balls[b].m);
		if (tot == 0) return;
		nx = (dx * 65536) / dist_v;
		ny = (dy * 65536) / dist_v;
		rvn = fdiv((longint'(balls[b].vx) - longint'(balls[a].vx)) * nx +
			(longint'(balls[b].vy) - longint'(balls[a].vy)) * ny, 65536);
		ov = dmin - dist_v;
		s1 = longint'((longint'(balls[a].m) << 16) / tot);
		s2 = longint'((longint'(balls[b].m) << 16) / tot);
		balls[a].x = clip32(balls[a].x - fdiv(nx * ov * s2, 64'sd1 << 32));
		balls[a].y = clip32(balls[a].y - fdiv(ny * ov * s2, 64'sd1 << 32));
		balls[b].x = clip32(balls[b].x + fdiv(nx * ov * s1, 64'sd1 << 32));
		balls[b].y = clip32(balls[b].y + fdiv(ny * ov * s1, 64'sd1 << 32));
		if (rvn > 0) return;
		e = balls[a].e < balls[b].e ? balls[a].e : balls[b].e;
		imp = fdiv((65536 + e) * (-rvn), 65536);
		w1 = fdiv(imp * s2, 65536);
		w2 = fdiv(imp * s1, 65536);
		balls[a].vx = clip32(balls[a].vx - fdiv(w1 * nx, 65536));
		balls[a].vy = clip32(balls[a].vy - fdiv(w1 * ny, 65536));
		balls[b].vx = clip32(balls[b].vx + fdiv(w2 * nx, 65536));
		balls[b].vy = clip32(balls[b].vy + fdiv(w2 * ny, 65536));
	endtask

	task automatic run_tick();
		ball_report_t rep;
		for (int i = 0; i < BALL_COUNT; i++) advance_ball(i);
		for (int i = 0; i < BALL_COUNT; i++)
			for (int j = i + 1; j < BALL_COUNT; j++) collide(i, j);
		for (int i = 0; i < BALL_COUNT; i++) begin
			rep.idx = i[3:0];
			rep.x = balls[i].x; rep.y = balls[i].y;
			rep.vx = balls[i].vx; rep.vy = balls[i].vy;
			rep.lst = (i == BALL_COUNT - 1);
			expected_reports.push_back(rep);
		end
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("  result mismatch on %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		ball_report_t want;
		if (!arst_n) begin
			grav_q   <= GRAVITY_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			rest_q   <= REST_RST;
			errors = 0;
			expected_reports.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GRAVITY: grav_q <= cfg_data;
					REG_WIDTH:   width_q <= cfg_data[11:0];
					REG_HEIGHT:  height_q <= cfg_data[11:0];
					REG_REST:    rest_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (kind == KIND_LOAD) begin
					if (ball_index < BALL_COUNT)
						balls[ball_index] = '{load_x, load_y, load_vx, load_vy, load_radius,
							load_mass, load_elasticity, load_friction};
				end else
					run_tick();
			end
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0)
					report_mismatch("unexpected result index", out_index, -1);
				else begin
					want = expected_reports.pop_front();
					if (out_index !== want.idx) report_mismatch("index", out_index, want.idx);
					if (out_x !== want.x) report_mismatch("x", out_x, want.x);
					if (out_y !== want.y) report_mismatch("y", out_y, want.y);
					if (out_vx !== want.vx) report_mismatch("vx", out_vx, want.vx);
					if (out_vy !== want.vy) report_mismatch("vy", out_vy, want.vy);
					if (last !== want.lst) report_mismatch("last", last, want.lst);
				end
			end
		end
	end

endmodule

### verif/ball_physics_step_top_tb.sv
// Testbench top for ball_physics_step_top: drives loads, ticks and register writes,
// random idling on both channels. Depends on bps_pkg and ball_physics_step_checker.
module ball_physics_step_top_tb;
	import bps_pkg::*;

	localparam int NB = BALL_COUNT_DEF;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int SETTLE_CYCLES = 1500;	// quiet margin after the last result
	localparam logic KIND_LOAD = 1'b0, KIND_TICK = 1'b1;
	localparam logic [1:0] REG_GRAVITY = 2'd0, REG_WIDTH = 2'd1, REG_HEIGHT = 2'd2,
		REG_REST = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [20:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = 1'b0;
	logic [3:0] ball_index = '0;
	logic signed [31:0] load_x = '0, load_y = '0, load_vx = '0, load_vy = '0;
	logic [25:0] load_radius = '0;
	logic [31:0] load_mass = '0;
	logic [16:0] load_elasticity = '0;
	logic [31:0] load_friction = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [3:0] out_index;
	logic signed [31:0] out_x, out_y, out_vx, out_vy;
	logic last;

	int errors, pending;
	int cycle_count = 0;
	bit quiet_phase = 1'b0;	// no idling on either side in the final stretch
	bit hold_request = 1'b0;	// asks the receiver for one long hold-off

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ball_physics_step_top u_dut (.*);

	ball_physics_step_checker u_chk (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ball_physics_step_top: mismatch");
			$finish;
		end
	end

	// Receiver: random stall bursts, plus one long hold-off while ticks keep coming.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (3000) @(posedge clk);
				out_stall <= 1'b0;
				hold_request = 1'b0;
			end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 18);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end else
				@(posedge clk);
		end
	end

	// One transfer on the input channel, with an optional idle burst ahead of it.
	task automatic send(logic k, logic [3:0] idx, logic signed [31:0] px, py, pvx, pvy,
			logic [25:0] rad, logic [31:0] mass, logic [16:0] el, logic [31:0] fr);
		if (!quiet_phase && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k; ball_index <= idx;
		load_x <= px; load_y <= py; load_vx <= pvx; load_vy <= pvy;
		load_radius <= rad; load_mass <= mass; load_elasticity <= el; load_friction <= fr;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic tick();
		send(KIND_TICK, 4'($urandom), $urandom, $urandom, $urandom, $urandom,
			26'($urandom), $urandom, 17'($urandom), $urandom);
	endtask

	// A ball inside the box, sized so that neighbors often touch, or a fully random one when wild.
	task automatic load_ball(logic [3:0] idx, bit wild);
		logic signed [31:0] px, py, pvx, pvy;
		logic [25:0] rad;
		logic [31:0] mass, fr;
		logic [16:0] el;
		if (wild) begin
			px = $urandom; py = $urandom; pvx = $urandom; pvy = $urandom;
			rad = 26'($urandom); mass = $urandom; fr = $urandom;
			el = 17'($urandom_range(0, 65536));
		end else begin
			px = $urandom_range(0, 300) << 16 | $urandom_range(0, 65535);
			py = $urandom_range(0, 300) << 16 | $urandom_range(0, 65535);
			pvx = $signed($urandom_range(0, 20 << 16)) - (10 << 16);
			pvy = $signed($urandom_range(0, 20 << 16)) - (10 << 16);
			rad = 26'($urandom_range(1 << 16, 80 << 16));
			mass = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1 << 14, 50 << 16);
			fr = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4 << 16);
			el = 17'($urandom_range(0, 65536));
		end
		send(KIND_LOAD, idx, px, py, pvx, pvy, rad, mass, el, fr);
	endtask

	task automatic set_reg(logic [1:0] idx, logic [20:0] val);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme fields, out-of-range index, overlapping and stacked balls.
		send(KIND_LOAD, 4'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			26'h3FF_FFFF, 32'hFFFF_FFFF, 17'd65536, 32'hFFFF_FFFF);
		send(KIND_LOAD, 4'd1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			'0, 32'd0, '0, '0);
		send(KIND_LOAD, 4'd2, 100 << 16, 100 << 16, 5 << 16, 0, 26'(20 << 16), 1 << 16,
			17'd65536, 0);
		send(KIND_LOAD, 4'd3, 100 << 16, 100 << 16, -5 << 16, 0, 26'(20 << 16), 0, 17'd0,
			1 << 16);
		send(KIND_LOAD, 4'd15, 32'sd1, 32'sd2, 32'sd3, 32'sd4, 26'd5, 32'd6, 17'd7, 32'd8);
		tick();
		tick();
		send(KIND_LOAD, 4'd0, 1000 << 16, 1079 << 16, 3 << 16, 1 << 14, 26'(10 << 16), 2 << 16,
			17'd30000, 1 << 16);
		send(KIND_LOAD, 4'd1, 1015 << 16, 1079 << 16, -3 << 16, 0, 26'(10 << 16), 1 << 16,
			17'd65536, 32'hFFFF_FFFF);
		send(KIND_LOAD, 4'd2, 5 << 16, 5 << 16, -8 << 16, -8 << 16, 26'(8 << 16), 0, 17'd0, 0);
		send(KIND_LOAD, 4'd3, 1915 << 16, 500 << 16, 9 << 16, 0, 26'(8 << 16), 1, 17'd65536, 0);
		tick();
		tick();
		tick();

		// Random phases under several register settings, extremes among them.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				1: begin
					set_reg(REG_GRAVITY, 21'd0);
					set_reg(REG_REST, 21'd0);
				end
				2: begin
					set_reg(REG_GRAVITY, 21'd1048576);
					set_reg(REG_WIDTH, 21'd1);
					set_reg(REG_HEIGHT, 21'd1);
					set_reg(REG_REST, 21'd1048576);
				end
				3: begin
					set_reg(REG_GRAVITY, 21'h1F_FFFF);
					set_reg(REG_WIDTH, 21'd4095);
					set_reg(REG_HEIGHT, 21'd4095);
					set_reg(REG_REST, 21'h1F_FFFF);
				end
				4: begin
					set_reg(REG_GRAVITY, 21'($urandom_range(0, 1 << 17)));
					set_reg(REG_WIDTH, 21'($urandom_range(300, 2000)));
					set_reg(REG_HEIGHT, 21'($urandom_range(300, 2000)));
					set_reg(REG_REST, 21'($urandom_range(0, 1 << 17)));
				end
				5: begin
					set_reg(REG_GRAVITY, 21'd26214);
					set_reg(REG_WIDTH, 21'd400);
					set_reg(REG_HEIGHT, 21'd400);
					set_reg(REG_REST, 21'd22348);
					quiet_phase = 1'b1;
				end
				default: ;
			endcase
			for (int b = 0; b < NB; b++) load_ball(4'(b), phase == 3);
			if (phase == 2) hold_request = 1'b1;	// fills the block while results back up
			for (int it = 0; it < 38; it++) begin
				if ($urandom_range(0, 5) == 0)
					load_ball(4'($urandom_range(0, 15)), $urandom_range(0, 7) == 0);
				else
					tick();
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);

		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("ball_physics_step_top: match");
		else
			$display("ball_physics_step_top: mismatch");
		$finish;
	end

endmodule
